// ===== hw/rtl/gyit_pkg.sv =====
package gyit_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BIAS_X   = 3'd0;
  localparam logic [2:0] REG_BIAS_Y   = 3'd1;
  localparam logic [2:0] REG_BIAS_Z   = 3'd2;
  localparam logic [2:0] REG_VERT_AX  = 3'd3;
  localparam logic [2:0] REG_VERT_NEG = 3'd4;
  localparam logic [2:0] REG_PERIOD   = 3'd5;
  localparam logic [2:0] REG_SCALE    = 3'd6;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [19:0] PERIOD_RST = 20'd10000;
  localparam logic [31:0] SCALE_RST  = 32'd222786764;
  localparam logic [31:0] SETTLE_US  = 32'd200000;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DONE
  } state_e;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/gyit_in_if.sv =====
interface gyit_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_us;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, now_us, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, now_us, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

// ===== hw/rtl/gyit_out_if.sv =====
interface gyit_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [15:0] accel_x_out;
  logic signed [15:0] accel_y_out;
  logic signed [15:0] accel_z_out;
  logic [31:0]        sample_count;
  logic               fix_valid;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, accel_x_out, accel_y_out,
                  accel_z_out, sample_count, fix_valid, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, accel_x_out, accel_y_out,
                accel_z_out, sample_count, fix_valid, output ready);
endinterface

// ===== hw/rtl/gyro_yaw_integrate_accel_tilt_core.sv =====
// Steps: take the sample, check its timestamp, run the bit-serial shift-add multiplications
// (first product, reload, second product), then load the output register.
// One sample is worked on at a time, and the result load waits for the output to be free;
// both CORDIC lanes run alongside the multipliers. Too-early samples drop at the check.
// Reset: asynchronous, active low; clears yaw, timing, settle and count state and loads the
// register defaults (biases 0, Z vertical, period 10000 us, default yaw scale).
module gyro_yaw_integrate_accel_tilt_core #(
  parameter int unsigned ANGLE_BITS   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gyit_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gyit_pkg::CfgDataW-1:0]  cfg_data_i,
  gyit_in_if.sink                        samp_i,
  gyit_out_if.source                     res_o
);
  import gyit_pkg::*;

  localparam int unsigned ANGLE_SHIFT = 32 - ANGLE_BITS;
  localparam int unsigned STEPS_EFF   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  // first multiply: |rate| (21 bits) by elapsed (22 bits)
  localparam int unsigned M1A = 21;
  localparam int unsigned M1B = 22;
  // second multiply: magnitude (43 bits) by scale (32 bits)
  localparam int unsigned M2A = M1A + M1B;
  localparam int unsigned M2B = 32;
  localparam logic [5:0]  M2_LOAD = 6'(M1B);
  localparam logic [5:0]  M_END   = 6'(M1B + 1 + M2B);
  localparam int unsigned CW  = 34;  // CORDIC x/y width

  // top ANGLE_BITS of a turn count, kept to the 16-bit field
  function automatic logic [15:0] o_ang(input logic [31:0] t);
    logic [31:0] s;
    s = t >> ANGLE_SHIFT;
    return s[15:0];
  endfunction

  // configuration registers
  logic signed [19:0] bias_q [3];
  logic [1:0]         vert_ax_q;
  logic               vert_neg_q;
  logic [19:0]        period_q;
  logic [31:0]        scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q[0]  <= '0;
      bias_q[1]  <= '0;
      bias_q[2]  <= '0;
      vert_ax_q  <= AXIS_Z;
      vert_neg_q <= 1'b0;
      period_q   <= PERIOD_RST;
      scale_q    <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIAS_X:   bias_q[0]  <= cfg_data_i[19:0];
        REG_BIAS_Y:   bias_q[1]  <= cfg_data_i[19:0];
        REG_BIAS_Z:   bias_q[2]  <= cfg_data_i[19:0];
        REG_VERT_AX:  vert_ax_q  <= cfg_data_i[1:0];
        REG_VERT_NEG: vert_neg_q <= cfg_data_i[0];
        REG_PERIOD:   period_q   <= cfg_data_i[19:0];
        REG_SCALE:    scale_q    <= cfg_data_i[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // control state
  state_e state_q, state_d;
  logic [31:0] last_time_q, settle_time_q, count_q, yaw_q;
  logic        settled_q, fix_q;
  logic [5:0]  mcnt_q;
  logic [5:0]  ccnt_q;
  logic        out_valid_q;

  // sample held for the duration of the work
  logic [31:0]        now_q;
  logic signed [15:0] gyro_q [3];
  logic signed [15:0] acc_q [3];

  // datapath
  logic               neg_q;
  logic [M1A-1:0]     absrate_q;
  logic [M1A+M1B:0]   pr1_q;
  logic [M2A+M2B:0]   pr2_q;
  logic signed [CW-1:0] cx_q [2];
  logic signed [CW-1:0] cy_q [2];
  logic [31:0]        cz_q [2];
  logic               czero_q [2];

  // output register
  logic signed [15:0] o_yaw_q, o_pitch_q, o_roll_q, o_ax_q, o_ay_q, o_az_q;
  logic [31:0]        o_count_q;
  logic               o_fix_q;

  // timestamp check
  logic [31:0] elapsed;
  logic        too_soon, clamp;
  logic [M1B-1:0] el_use;
  assign elapsed  = now_q - last_time_q;
  assign too_soon = elapsed < {12'd0, period_q};
  assign clamp    = elapsed > {10'd0, period_q, 2'b00};
  assign el_use   = clamp ? {2'b00, period_q} : elapsed[M1B-1:0];

  // axis selection; axis code three acts as X
  logic [1:0] v_ax, p_ax, r_ax;
  always_comb begin
    v_ax = (vert_ax_q == 2'd3) ? AXIS_X : vert_ax_q;
    unique case (v_ax)
      AXIS_X:  begin p_ax = AXIS_Y; r_ax = AXIS_Z; end
      AXIS_Y:  begin p_ax = AXIS_Z; r_ax = AXIS_X; end
      default: begin p_ax = AXIS_X; r_ax = AXIS_Y; end
    endcase
  end

  // bias-corrected, signed vertical rate in raw counts with four fraction bits
  logic signed [21:0] rate_raw, rate;
  logic [21:0]        rate_abs;
  logic signed [15:0] g_v;
  logic signed [19:0] b_v;
  assign g_v      = gyro_q[v_ax];
  assign b_v      = bias_q[v_ax];
  assign rate_raw = {{2{g_v[15]}}, g_v, 4'b0000} - {{2{b_v[19]}}, b_v};
  assign rate     = vert_neg_q ? -rate_raw : rate_raw;
  assign rate_abs = rate[21] ? 22'(-rate) : 22'(rate);

  // CORDIC lane set-up: lane 0 pitch, lane 1 roll
  logic signed [16:0] vert;
  assign vert = vert_neg_q ? -{acc_q[v_ax][15], acc_q[v_ax]} : {acc_q[v_ax][15], acc_q[v_ax]};

  logic signed [CW-1:0] cx_init [2];
  logic signed [CW-1:0] cy_init [2];
  logic [31:0]          cz_init [2];
  logic                 czero_init [2];
  logic signed [CW-1:0] cx_next [2];
  logic signed [CW-1:0] cy_next [2];
  logic [31:0]          cz_next [2];
  logic [31:0]          angle_turn;
  assign angle_turn = atan_turn(ccnt_q[4:0]);

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [17:0] x0, y0, xi, yi;
    logic signed [CW-1:0] xs, ys;
    assign x0 = {vert[16], vert};
    assign y0 = (l == 0) ? {{2{acc_q[p_ax][15]}}, acc_q[p_ax]}
                         : {{2{acc_q[r_ax][15]}}, acc_q[r_ax]};
    assign xi = x0[17] ? -x0 : x0;
    assign yi = x0[17] ? -y0 : y0;
    assign cx_init[l]    = {{2{xi[17]}}, xi, 14'd0};
    assign cy_init[l]    = {{2{yi[17]}}, yi, 14'd0};
    assign cz_init[l]    = x0[17] ? HALF_TURN : 32'd0;
    assign czero_init[l] = (x0 == 18'sd0) && (y0 == 18'sd0);

    assign xs = cx_q[l] >>> ccnt_q[4:0];
    assign ys = cy_q[l] >>> ccnt_q[4:0];
    always_comb begin
      if (!cy_q[l][CW-1]) begin
        cx_next[l] = cx_q[l] + ys;
        cy_next[l] = cy_q[l] - xs;
        cz_next[l] = cz_q[l] + angle_turn;
      end else begin
        cx_next[l] = cx_q[l] - ys;
        cy_next[l] = cy_q[l] + xs;
        cz_next[l] = cz_q[l] - angle_turn;
      end
    end
  end

  // shift-add multiplier steps: add multiplicand on the low multiplier bit, shift right
  logic [M1A+1:0] sum1;
  logic [M2A+1:0] sum2;
  assign sum1 = {1'b0, pr1_q[M1A+M1B:M1B]} + (pr1_q[0] ? {2'b00, absrate_q} : '0);
  assign sum2 = {1'b0, pr2_q[M2A+M2B:M2B]} + (pr2_q[0] ? {2'b00, pr1_q[M2A-1:0]} : '0);

  // yaw increment: floor of the scaled product, or minus its ceiling for a negative rate
  logic [31:0] inc_mag, inc;
  logic        lo_nz;
  assign lo_nz   = |pr2_q[31:0];
  assign inc_mag = pr2_q[63:32] + {31'd0, neg_q & lo_nz};
  assign inc     = neg_q ? -inc_mag : inc_mag;

  // settle window
  logic [31:0] settle_base;
  assign settle_base = settled_q ? settle_time_q : now_q;

  logic in_take, out_free;
  assign in_take  = samp_i.valid && samp_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_take) state_d = ST_CHECK;
      ST_CHECK: state_d = too_soon ? ST_IDLE : ST_RUN;
      ST_RUN:   if (mcnt_q == M_END) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign samp_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      last_time_q   <= '0;
      settle_time_q <= '0;
      settled_q     <= 1'b0;
      fix_q         <= 1'b0;
      count_q       <= '0;
      yaw_q         <= '0;
      mcnt_q        <= '0;
      ccnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // drop the held result once transferred, unless a new one is loaded this cycle
      if (res_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CHECK: if (!too_soon) begin
          last_time_q <= now_q;
          count_q     <= count_q + 32'd1;
          settled_q   <= 1'b1;
          if (!settled_q) settle_time_q <= now_q;
          if (!fix_q && (now_q - settle_base) > SETTLE_US) fix_q <= 1'b1;
          mcnt_q <= '0;
          ccnt_q <= '0;
        end
        ST_RUN: begin
          mcnt_q <= mcnt_q + 6'd1;
          if (ccnt_q < 6'(STEPS_EFF)) ccnt_q <= ccnt_q + 6'd1;
          if (mcnt_q == M_END) yaw_q <= yaw_q + inc;
        end
        ST_DONE: if (out_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q    <= samp_i.now_us;
      gyro_q[0] <= samp_i.gyro_x;
      gyro_q[1] <= samp_i.gyro_y;
      gyro_q[2] <= samp_i.gyro_z;
      acc_q[0]  <= samp_i.accel_x;
      acc_q[1]  <= samp_i.accel_y;
      acc_q[2]  <= samp_i.accel_z;
    end
    if (state_q == ST_CHECK) begin
      neg_q     <= rate[21];
      absrate_q <= rate_abs[M1A-1:0];
      pr1_q     <= {{(M1A+1){1'b0}}, el_use};
      for (int l = 0; l < 2; l++) begin
        cx_q[l]    <= cx_init[l];
        cy_q[l]    <= cy_init[l];
        cz_q[l]    <= cz_init[l];
        czero_q[l] <= czero_init[l];
      end
    end
    if (state_q == ST_RUN) begin
      // advance the multiplier chain: first product, reload, second product
      if (mcnt_q < M2_LOAD) begin
        pr1_q <= {sum1, pr1_q[M1B-1:1]};
      end else if (mcnt_q == M2_LOAD) begin
        pr2_q <= {{(M2A+1){1'b0}}, scale_q};
      end else if (mcnt_q < M_END) begin
        pr2_q <= {sum2, pr2_q[M2B-1:1]};
      end
      if (ccnt_q < 6'(STEPS_EFF)) begin
        for (int l = 0; l < 2; l++) begin
          cx_q[l] <= cx_next[l];
          cy_q[l] <= cy_next[l];
          cz_q[l] <= cz_next[l];
        end
      end
    end
    if (state_q == ST_DONE && out_free) begin
      o_yaw_q   <= o_ang(yaw_q);
      o_pitch_q <= czero_q[0] ? 16'sd0 : o_ang(cz_q[0]);
      o_roll_q  <= czero_q[1] ? 16'sd0 : o_ang(cz_q[1]);
      o_ax_q    <= acc_q[0];
      o_ay_q    <= acc_q[1];
      o_az_q    <= acc_q[2];
      o_count_q <= count_q;
      o_fix_q   <= fix_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.yaw_angle    = o_yaw_q;
  assign res_o.pitch_angle  = o_pitch_q;
  assign res_o.roll_angle   = o_roll_q;
  assign res_o.accel_x_out  = o_ax_q;
  assign res_o.accel_y_out  = o_ay_q;
  assign res_o.accel_z_out  = o_az_q;
  assign res_o.sample_count = o_count_q;
  assign res_o.fix_valid    = o_fix_q;

endmodule
